/* rtl/vft_pkg.sv */
// ----------------------------------------------------------------------------
// vft_pkg: shared constants for the viewbox fit transform
// Fixed-point format, field widths and alignment / fit mode codes.
// ----------------------------------------------------------------------------
package vft_pkg;

    // fraction bits of the coordinate format (8 to 24)
    localparam int FRAC_BITS = 16;
    // fraction bits of the density register
    localparam int DENS_FRAC = 8;
    // total scale of the quotient, element width over scaled viewbox width
    localparam int SCL       = FRAC_BITS + DENS_FRAC;
    // right shift of the scale times viewbox anchor product
    localparam int PSHIFT    = SCL + 1;

    localparam int COORD_W   = 32;
    localparam int DENS_W    = 16;
    localparam int CODE_W    = 2;

    localparam logic [DENS_W-1:0] DENS_RESET = DENS_W'(256);

    // alignment codes
    localparam logic [CODE_W-1:0] ALIGN_MIN = 2'd0;
    localparam logic [CODE_W-1:0] ALIGN_MID = 2'd1;
    localparam logic [CODE_W-1:0] ALIGN_MAX = 2'd2;

    // fit mode codes
    localparam logic [CODE_W-1:0] FIT_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] FIT_MEET  = 2'd1;
    localparam logic [CODE_W-1:0] FIT_SLICE = 2'd2;

endpackage

/* rtl/vft_if.sv */
// ----------------------------------------------------------------------------
// vft_req_if / vft_rsp_if: request and result channels
// Valid/ready channels carrying one rectangle pair or one transform.
// ----------------------------------------------------------------------------
interface vft_req_if import vft_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [COORD_W-1:0]   vb_left;
    logic signed [COORD_W-1:0]   vb_top;
    logic signed [COORD_W-1:0]   vb_right;
    logic signed [COORD_W-1:0]   vb_bottom;
    logic signed [COORD_W-1:0]   elem_left;
    logic signed [COORD_W-1:0]   elem_top;
    logic signed [COORD_W-1:0]   elem_right;
    logic signed [COORD_W-1:0]   elem_bottom;
    logic        [CODE_W-1:0]    align_x;
    logic        [CODE_W-1:0]    align_y;
    logic                        align_none;
    logic        [CODE_W-1:0]    fit_mode;

    modport source (
        output valid, vb_left, vb_top, vb_right, vb_bottom,
               elem_left, elem_top, elem_right, elem_bottom,
               align_x, align_y, align_none, fit_mode,
        input  ready
    );
    modport sink (
        input  valid, vb_left, vb_top, vb_right, vb_bottom,
               elem_left, elem_top, elem_right, elem_bottom,
               align_x, align_y, align_none, fit_mode,
        output ready
    );
endinterface

interface vft_rsp_if import vft_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [COORD_W-1:0]   scale_x;
    logic signed [COORD_W-1:0]   scale_y;
    logic signed [COORD_W-1:0]   shift_x;
    logic signed [COORD_W-1:0]   shift_y;
    logic                        zero_extent;

    modport source (
        output valid, scale_x, scale_y, shift_x, shift_y, zero_extent,
        input  ready
    );
    modport sink (
        input  valid, scale_x, scale_y, shift_x, shift_y, zero_extent,
        output ready
    );
endinterface

/* rtl/viewbox_fit_transform.sv */
// ----------------------------------------------------------------------------
// viewbox_fit_transform: viewbox to element fit transform
// Scales the viewbox by the density register and returns the x/y scale and
// translation that fit it onto the element rectangle, saturated fixed point.
// ----------------------------------------------------------------------------
//  channel  | dir | transfer when          | payload
//  i_req    | in  | valid & ready          | viewbox edges, element edges, modes
//  o_rsp    | out | valid & ready          | scale_x/y, shift_x/y, zero_extent
//  cfg      | in  | i_cfg_we high          | density, unsigned Q8.8
//
//  42 register stages; one transfer per cycle sustained while o_rsp takes
//  results. The depth is set by the restoring divider: one quotient bit per
//  stage. Synchronous active-low reset clears the stage valid bits and sets
//  the density back to 1.0; the data registers are not reset. Each stage
//  holds when the stage after it is full and stalled, so empty stages close
//  up and the input keeps taking transfers.
// ----------------------------------------------------------------------------
module viewbox_fit_transform import vft_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [DENS_W-1:0]  i_cfg_wdata,
    vft_req_if.sink            i_req,
    vft_rsp_if.source          o_rsp
);

    localparam int QW     = 32;               // quotient bits
    localparam int DW     = 49;               // divisor / remainder / anchor bits
    localparam int EW     = COORD_W + 1;      // edge difference bits
    localparam int AW     = COORD_W + 2;      // doubled anchor bits
    localparam int CAPW   = 41;               // clamped product bits
    localparam int PW     = QW + DW + 1;      // full product bits
    localparam int S_DIV  = 3;                // first divider stage
    localparam int NDIV   = QW + 1;           // init plus one stage per bit
    localparam int NST    = S_DIV + NDIV + 6; // total stages
    localparam int S_SAT  = S_DIV + NDIV;
    localparam int S_SEL  = S_SAT + 1;
    localparam int S_MAG  = S_SAT + 2;
    localparam int S_PP   = S_SAT + 3;
    localparam int S_SUM  = S_SAT + 4;
    localparam int S_OUT  = S_SAT + 5;

    localparam logic [1:0] SEL_KEEP = 2'd0;
    localparam logic [1:0] SEL_MIN  = 2'd1;
    localparam logic [1:0] SEL_MAX  = 2'd2;

    localparam logic [CAPW-1:0] PCAP = CAPW'(1) << (CAPW - 1);

    typedef struct packed {
        logic signed [EW-1:0] e_w;
        logic signed [EW-1:0] v_w;
        logic signed [AW-1:0] va;
        logic signed [EW-1:0] ea;
    } t_a0;

    typedef struct packed {
        logic signed [EW-1:0] e_w;
        logic signed [DW-1:0] vw;
        logic signed [DW:0]   va;
        logic signed [EW-1:0] ea;
    } t_a1;

    // per-axis data that rides alongside the scale
    typedef struct packed {
        logic [DW-1:0]        amag;
        logic                 aneg;
        logic signed [EW-1:0] ea;
    } t_side;

    typedef struct packed {
        logic [EW-1:0] num;
        logic [DW-1:0] den;
        logic          qneg;
        t_side         sd;
    } t_a2;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [DW-1:0] den;
        logic [QW-1:0] nlo;
        logic [QW-1:0] q;
        logic          ovf;
        logic          qneg;
        t_side         sd;
    } t_ad;

    typedef struct packed {
        logic [1:0] sel;
        logic       zero;
    } t_ctl;

    // registers
    logic [DENS_W-1:0]        r_density;
    logic [NST-1:0]           r_vld;
    logic [NST-1:0]           n_en;

    t_a0                      r0_x, r0_y;
    logic [DENS_W-1:0]        r0_dens;
    logic [1:0]               r0_sel, r1_sel;
    t_a1                      r1_x, r1_y;
    t_a2                      r2_x, r2_y;
    t_ctl                     r2_ctl;
    t_ad                      r_dx [NDIV];
    t_ad                      r_dy [NDIV];
    t_ctl                     r_dc [NDIV];
    logic signed [QW-1:0]     r_sat_x, r_sat_y, r_sel_x, r_sel_y;
    t_side                    r_sat_sx, r_sat_sy, r_sel_sx, r_sel_sy;
    logic [QW-1:0]            r_mag_x, r_mag_y;
    logic                     r_mag_nx, r_mag_ny, r_pp_nx, r_pp_ny, r_sum_nx, r_sum_ny;
    logic [DW-1:0]            r_mag_ax, r_mag_ay;
    logic signed [EW-1:0]     r_mag_ex, r_mag_ey, r_pp_ex, r_pp_ey, r_sum_ex, r_sum_ey;
    logic [2*QW-1:0]          r_plo_x, r_plo_y;
    logic [DW-1:0]            r_phi_x, r_phi_y;
    logic [CAPW-1:0]          r_q_x, r_q_y;
    t_ctl                     r_sat_c, r_sel_c, r_mag_c, r_pp_c, r_sum_c;
    logic signed [QW-1:0]     r_mag_sx, r_mag_sy, r_pp_sx, r_pp_sy;
    logic signed [QW-1:0]     r_sel_out_x, r_sel_out_y;
    logic signed [QW-1:0]     r_out_sx, r_out_sy, r_out_tx, r_out_ty;
    logic                     r_out_z;

    // density register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_density <= DENS_RESET;
        end else if (i_cfg_we) begin
            r_density <= i_cfg_wdata;
        end
    end

    // stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        n_en[NST-1] = !r_vld[NST-1] || o_rsp.ready;
        for (int i = NST - 2; i >= 0; i--) begin
            n_en[i] = !r_vld[i] || n_en[i+1];
        end
    end

    assign i_req.ready = n_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (n_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // anchor code after mode rules
    function automatic logic [CODE_W-1:0] anchor_code(
        input logic [CODE_W-1:0] fm,
        input logic              an,
        input logic [CODE_W-1:0] a
    );
        logic [CODE_W-1:0] k;
        if (fm == FIT_NONE) begin
            k = ALIGN_MID;
        end else if (an) begin
            k = ALIGN_MIN;
        end else begin
            unique case (a)
                ALIGN_MID: k = ALIGN_MID;
                ALIGN_MAX: k = ALIGN_MAX;
                default:   k = ALIGN_MIN;
            endcase
        end
        return k;
    endfunction

    function automatic t_a0 stage0(
        input logic signed [COORD_W-1:0] vlo,
        input logic signed [COORD_W-1:0] vhi,
        input logic signed [COORD_W-1:0] elo,
        input logic signed [COORD_W-1:0] ehi,
        input logic [CODE_W-1:0]         k
    );
        t_a0                  r;
        logic signed [AW-1:0] esum;
        r.e_w = EW'(ehi) - EW'(elo);
        r.v_w = EW'(vhi) - EW'(vlo);
        esum  = AW'(ehi) + AW'(elo);
        unique case (k)
            ALIGN_MID: begin
                r.va = AW'(vhi) + AW'(vlo);
                r.ea = EW'(esum >>> 1);
            end
            ALIGN_MAX: begin
                r.va = AW'(vhi) <<< 1;
                r.ea = EW'(ehi);
            end
            default: begin
                r.va = AW'(vlo) <<< 1;
                r.ea = EW'(elo);
            end
        endcase
        return r;
    endfunction

    // stage 0: edge differences and anchors
    always_ff @(posedge i_clk) begin
        if (n_en[0]) begin
            r0_x <= stage0(i_req.vb_left, i_req.vb_right, i_req.elem_left,
                           i_req.elem_right,
                           anchor_code(i_req.fit_mode, i_req.align_none, i_req.align_x));
            r0_y <= stage0(i_req.vb_top, i_req.vb_bottom, i_req.elem_top,
                           i_req.elem_bottom,
                           anchor_code(i_req.fit_mode, i_req.align_none, i_req.align_y));
            r0_dens <= r_density;
            if (i_req.fit_mode == FIT_NONE) begin
                r0_sel <= SEL_MIN;
            end else if (!i_req.align_none && i_req.fit_mode == FIT_MEET) begin
                r0_sel <= SEL_MIN;
            end else if (!i_req.align_none && i_req.fit_mode == FIT_SLICE) begin
                r0_sel <= SEL_MAX;
            end else begin
                r0_sel <= SEL_KEEP;
            end
        end
    end

    // stage 1: density multiply
    function automatic t_a1 stage1(input t_a0 a, input logic [DENS_W-1:0] d);
        t_a1                     r;
        logic signed [DENS_W:0]  ds;
        ds    = $signed({1'b0, d});
        r.e_w = a.e_w;
        r.vw  = DW'(a.v_w * ds);
        r.va  = (DW+1)'(a.va * ds);
        r.ea  = a.ea;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (n_en[1]) begin
            r1_x   <= stage1(r0_x, r0_dens);
            r1_y   <= stage1(r0_y, r0_dens);
            r1_sel <= r0_sel;
        end
    end

    // stage 2: magnitudes and signs
    function automatic t_a2 stage2(input t_a1 a);
        t_a2 r;
        r.num     = a.e_w[EW-1] ? EW'(-a.e_w) : EW'(a.e_w);
        r.den     = a.vw[DW-1] ? DW'(-a.vw) : DW'(a.vw);
        r.qneg    = a.e_w[EW-1] ^ a.vw[DW-1];
        r.sd.amag = a.va[DW] ? DW'(-a.va) : DW'(a.va);
        r.sd.aneg = a.va[DW];
        r.sd.ea   = a.ea;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (n_en[2]) begin
            r2_x        <= stage2(r1_x);
            r2_y        <= stage2(r1_y);
            r2_ctl.sel  <= r1_sel;
            r2_ctl.zero <= (r1_x.vw == '0) || (r1_y.vw == '0);
        end
    end

    // divider setup: high part of the shifted numerator, overflow check
    function automatic t_ad div_init(input t_a2 a);
        t_ad r;
        r.rem  = DW'(a.num >> (QW - SCL));
        r.den  = a.den;
        r.nlo  = QW'({a.num, {SCL{1'b0}}});
        r.q    = '0;
        r.ovf  = (DW'(a.num >> (QW - SCL)) >= a.den);
        r.qneg = a.qneg;
        r.sd   = a.sd;
        return r;
    endfunction

    // one restoring division step
    function automatic t_ad div_step(input t_ad a);
        t_ad           r;
        logic [DW-1:0] sh;
        r  = a;
        sh = {a.rem[DW-2:0], a.nlo[QW-1]};
        r.nlo = {a.nlo[QW-2:0], 1'b0};
        if (sh >= a.den) begin
            r.rem = sh - a.den;
            r.q   = {a.q[QW-2:0], 1'b1};
        end else begin
            r.rem = sh;
            r.q   = {a.q[QW-2:0], 1'b0};
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (n_en[S_DIV]) begin
            r_dx[0] <= div_init(r2_x);
            r_dy[0] <= div_init(r2_y);
            r_dc[0] <= r2_ctl;
        end
    end

    // divider stages, one quotient bit each
    for (genvar g = 1; g < NDIV; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (n_en[S_DIV+g]) begin
                r_dx[g] <= div_step(r_dx[g-1]);
                r_dy[g] <= div_step(r_dy[g-1]);
                r_dc[g] <= r_dc[g-1];
            end
        end
    end

    // signed saturated scale
    function automatic logic signed [QW-1:0] sat_scale(input t_ad a);
        logic signed [QW-1:0] s;
        if (a.ovf || a.q[QW-1]) begin
            s = a.qneg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        end else begin
            s = a.qneg ? -$signed(a.q) : $signed(a.q);
        end
        return s;
    endfunction

    always_ff @(posedge i_clk) begin
        if (n_en[S_SAT]) begin
            r_sat_x  <= sat_scale(r_dx[NDIV-1]);
            r_sat_y  <= sat_scale(r_dy[NDIV-1]);
            r_sat_sx <= r_dx[NDIV-1].sd;
            r_sat_sy <= r_dy[NDIV-1].sd;
            r_sat_c  <= r_dc[NDIV-1];
        end
    end

    // scale equalization per fit mode
    always_ff @(posedge i_clk) begin
        if (n_en[S_SEL]) begin
            unique case (r_sat_c.sel)
                SEL_MIN: begin
                    r_sel_x <= (r_sat_x < r_sat_y) ? r_sat_x : r_sat_y;
                    r_sel_y <= (r_sat_x < r_sat_y) ? r_sat_x : r_sat_y;
                end
                SEL_MAX: begin
                    r_sel_x <= (r_sat_x > r_sat_y) ? r_sat_x : r_sat_y;
                    r_sel_y <= (r_sat_x > r_sat_y) ? r_sat_x : r_sat_y;
                end
                default: begin
                    r_sel_x <= r_sat_x;
                    r_sel_y <= r_sat_y;
                end
            endcase
            r_sel_sx <= r_sat_sx;
            r_sel_sy <= r_sat_sy;
            r_sel_c  <= r_sat_c;
        end
    end

    // scale magnitude and product sign
    always_ff @(posedge i_clk) begin
        if (n_en[S_MAG]) begin
            r_mag_x  <= r_sel_x[QW-1] ? QW'(-r_sel_x) : QW'(r_sel_x);
            r_mag_y  <= r_sel_y[QW-1] ? QW'(-r_sel_y) : QW'(r_sel_y);
            r_mag_nx <= r_sel_x[QW-1] ^ r_sel_sx.aneg;
            r_mag_ny <= r_sel_y[QW-1] ^ r_sel_sy.aneg;
            r_mag_ax <= r_sel_sx.amag;
            r_mag_ay <= r_sel_sy.amag;
            r_mag_ex <= r_sel_sx.ea;
            r_mag_ey <= r_sel_sy.ea;
            r_mag_c  <= r_sel_c;
        end
    end

    // partial products, low and high anchor halves
    always_ff @(posedge i_clk) begin
        if (n_en[S_PP]) begin
            r_plo_x <= r_mag_x * r_mag_ax[QW-1:0];
            r_plo_y <= r_mag_y * r_mag_ay[QW-1:0];
            r_phi_x <= r_mag_x * r_mag_ax[DW-1:QW];
            r_phi_y <= r_mag_y * r_mag_ay[DW-1:QW];
            r_pp_nx <= r_mag_nx;
            r_pp_ny <= r_mag_ny;
            r_pp_ex <= r_mag_ex;
            r_pp_ey <= r_mag_ey;
            r_pp_c  <= r_mag_c;
        end
    end

    // product sum, scale down and clamp
    function automatic logic [CAPW-1:0] prod_q(
        input logic [2*QW-1:0]    lo,
        input logic [DW-1:0]      hi
    );
        logic [PW-1:0] p;
        logic [PW-1:0] s;
        p = PW'(lo) + (PW'(hi) << QW);
        s = p >> PSHIFT;
        return (s > PW'(PCAP)) ? PCAP : CAPW'(s);
    endfunction

    always_ff @(posedge i_clk) begin
        if (n_en[S_SUM]) begin
            r_q_x    <= prod_q(r_plo_x, r_phi_x);
            r_q_y    <= prod_q(r_plo_y, r_phi_y);
            r_sum_nx <= r_pp_nx;
            r_sum_ny <= r_pp_ny;
            r_sum_ex <= r_pp_ex;
            r_sum_ey <= r_pp_ey;
            r_sum_c  <= r_pp_c;
        end
    end

    // translation: element anchor minus signed product, saturated
    function automatic logic signed [QW-1:0] shift_sat(
        input logic signed [EW-1:0] ea,
        input logic [CAPW-1:0]      q,
        input logic                 neg
    );
        logic signed [CAPW+1:0] d;
        logic signed [CAPW+1:0] qs;
        qs = $signed({2'b00, q});
        d  = neg ? ((CAPW+2)'(ea) + qs) : ((CAPW+2)'(ea) - qs);
        if (d > (CAPW+2)'(33'sh07FFFFFFF)) begin
            return {1'b0, {(QW-1){1'b1}}};
        end else if (d < -(CAPW+2)'(33'sh080000000)) begin
            return {1'b1, {(QW-1){1'b0}}};
        end
        return QW'(d);
    endfunction

    // equalized scales follow the product path
    always_ff @(posedge i_clk) begin
        if (n_en[S_MAG]) begin
            r_mag_sx <= r_sel_x;
            r_mag_sy <= r_sel_y;
        end
        if (n_en[S_PP]) begin
            r_pp_sx <= r_mag_sx;
            r_pp_sy <= r_mag_sy;
        end
        if (n_en[S_SUM]) begin
            r_sel_out_x <= r_pp_sx;
            r_sel_out_y <= r_pp_sy;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (n_en[S_OUT]) begin
            r_out_z <= r_sum_c.zero;
            if (r_sum_c.zero) begin
                r_out_sx <= '0;
                r_out_sy <= '0;
                r_out_tx <= '0;
                r_out_ty <= '0;
            end else begin
                r_out_sx <= r_sel_out_x;
                r_out_sy <= r_sel_out_y;
                r_out_tx <= shift_sat(r_sum_ex, r_q_x, r_sum_nx);
                r_out_ty <= shift_sat(r_sum_ey, r_q_y, r_sum_ny);
            end
        end
    end

    assign o_rsp.valid       = r_vld[NST-1];
    assign o_rsp.scale_x     = r_out_sx;
    assign o_rsp.scale_y     = r_out_sy;
    assign o_rsp.shift_x     = r_out_tx;
    assign o_rsp.shift_y     = r_out_ty;
    assign o_rsp.zero_extent = r_out_z;

endmodule

/* tb/sv/vft_checker.sv */
// ----------------------------------------------------------------------------
// vft_checker: result predictor and scoreboard for the viewbox fit transform
// Watches the request and result channels and the density port, works out
// the expected scale and translation for every request transfer and compares
// each result transfer with the oldest expectation, field by field.
// ----------------------------------------------------------------------------
module vft_checker import vft_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [DENS_W-1:0]  i_cfg_wdata,
    vft_req_if                 req,
    vft_rsp_if                 rsp,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_zero_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [COORD_W-1:0] scale_x;
        logic signed [COORD_W-1:0] scale_y;
        logic signed [COORD_W-1:0] shift_x;
        logic signed [COORD_W-1:0] shift_y;
        logic                      zero_extent;
    } xform_t;

    localparam longint unsigned PRODUCT_CAP = 64'd1 << 40;

    logic [DENS_W-1:0] density;
    xform_t            xform_q[$];

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // element extent over scaled viewbox extent, quotient truncated toward zero
    function automatic longint ratio_scale(input longint e, input longint v);
        longint unsigned num, den, m;
        num = magnitude(e) << DENS_FRAC;
        den = magnitude(v);
        if (num / den >= (64'd1 << (COORD_W - FRAC_BITS)))
            m = 64'd1 << 32;
        else
            m = (num << FRAC_BITS) / den;
        return clamp32(((e < 0) != (v < 0)) ? -longint'(m) : longint'(m));
    endfunction

    // scale times doubled viewbox anchor, back to coordinate format, capped
    function automatic longint anchor_product(input longint s, input longint v);
        logic [127:0]    p;
        longint unsigned q;
        p = 128'(magnitude(s)) * 128'(magnitude(v));
        p = p >> PSHIFT;
        q = (p > 128'(PRODUCT_CAP)) ? PRODUCT_CAP : p[63:0];
        return ((s < 0) != (v < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // twice the anchor point of an edge pair
    function automatic longint anchor_x2(input longint lo, input longint hi,
                                         input logic [CODE_W-1:0] k);
        if (k == ALIGN_MID) return lo + hi;
        if (k == ALIGN_MAX) return 2 * hi;
        return 2 * lo;
    endfunction

    function automatic xform_t fit_transform(input logic [DENS_W-1:0] dens);
        xform_t                r;
        longint                d, vl, vt, vr, vb, el, et, er, eb, vw, vh;
        longint                sx, sy, s, tx, ty;
        logic [CODE_W-1:0]     ax, ay, kx, ky;
        d  = longint'(dens);
        vl = longint'(req.vb_left) * d;
        vt = longint'(req.vb_top) * d;
        vr = longint'(req.vb_right) * d;
        vb = longint'(req.vb_bottom) * d;
        el = longint'(req.elem_left);
        et = longint'(req.elem_top);
        er = longint'(req.elem_right);
        eb = longint'(req.elem_bottom);
        vw = vr - vl;
        vh = vb - vt;
        r  = '0;
        if (vw == 0 || vh == 0) begin
            r.zero_extent = 1'b1;
            return r;
        end
        sx = ratio_scale(er - el, vw);
        sy = ratio_scale(eb - et, vh);
        ax = (req.align_x == 2'd3) ? ALIGN_MIN : req.align_x;
        ay = (req.align_y == 2'd3) ? ALIGN_MIN : req.align_y;
        if (req.fit_mode == FIT_NONE) begin
            s  = (sx < sy) ? sx : sy;
            sx = s;
            sy = s;
            kx = ALIGN_MID;
            ky = ALIGN_MID;
        end else begin
            if (!req.align_none && req.fit_mode == FIT_MEET) begin
                s  = (sx < sy) ? sx : sy;
                sx = s;
                sy = s;
            end else if (!req.align_none && req.fit_mode == FIT_SLICE) begin
                s  = (sx > sy) ? sx : sy;
                sx = s;
                sy = s;
            end
            kx = req.align_none ? ALIGN_MIN : ax;
            ky = req.align_none ? ALIGN_MIN : ay;
        end
        tx = clamp32((anchor_x2(el, er, kx) >>> 1) - anchor_product(sx, anchor_x2(vl, vr, kx)));
        ty = clamp32((anchor_x2(et, eb, ky) >>> 1) - anchor_product(sy, anchor_x2(vt, vb, ky)));
        r.scale_x = sx[31:0];
        r.scale_y = sy[31:0];
        r.shift_x = tx[31:0];
        r.shift_y = ty[31:0];
        return r;
    endfunction

    // density shadow, predictions on request transfers, checks on result transfers
    always @(posedge i_clk) begin
        xform_t want;
        if (!i_rst_n) begin
            density <= DENS_RESET;
        end else begin
            if (i_cfg_we)
                density <= i_cfg_wdata;
            if (req.valid && req.ready)
                xform_q = {xform_q, fit_transform(density)};
            if (rsp.valid && rsp.ready) begin
                if (xform_q.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    o_errors <= o_errors + 1;
                end else begin
                    want = xform_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (want.zero_extent)
                        o_zero_seen <= o_zero_seen + 1;
                    if (rsp.scale_x !== want.scale_x ||
                        rsp.scale_y !== want.scale_y ||
                        rsp.shift_x !== want.shift_x ||
                        rsp.shift_y !== want.shift_y ||
                        rsp.zero_extent !== want.zero_extent)
                        o_errors <= o_errors + 1;
                    if (rsp.scale_x !== want.scale_x)
                        $error("scale_x expected %0d got %0d", want.scale_x, rsp.scale_x);
                    if (rsp.scale_y !== want.scale_y)
                        $error("scale_y expected %0d got %0d", want.scale_y, rsp.scale_y);
                    if (rsp.shift_x !== want.shift_x)
                        $error("shift_x expected %0d got %0d", want.shift_x, rsp.shift_x);
                    if (rsp.shift_y !== want.shift_y)
                        $error("shift_y expected %0d got %0d", want.shift_y, rsp.shift_y);
                    if (rsp.zero_extent !== want.zero_extent)
                        $error("zero_extent expected %0b got %0b",
                               want.zero_extent, rsp.zero_extent);
                end
            end
        end
    end

    assign o_pending = xform_q.size();

    initial begin
        o_errors    = 0;
        o_checked   = 0;
        o_zero_seen = 0;
    end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the viewbox fit transform
// Directed rectangle pairs first, then random phases at several density
// settings with sender gaps and receiver stalls; checking is in vft_checker.
// ----------------------------------------------------------------------------
module testbench;
    import vft_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 42;
    localparam int LIMIT   = 400000;
    localparam int Q       = 1 << FRAC_BITS;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [DENS_W-1:0] i_cfg_wdata;
    int                errors, pending, checked, zero_seen;
    int                idle_pct, stall_pct, cycles, sent;

    vft_req_if req ();
    vft_rsp_if rsp ();

    viewbox_fit_transform DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req),
        .o_rsp       (rsp)
    );

    vft_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .req         (req),
        .rsp         (rsp),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_zero_seen (zero_seen)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver stalls
    initial rsp.ready = 1'b0;
    always @(posedge i_clk) begin
        rsp.ready <= i_rst_n && ($urandom_range(99) >= stall_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one request transfer, with random sender gaps ahead of it
    task automatic issue(input logic [31:0] vbl, vbt, vbr, vbb, el, et, er, eb,
                         input logic [1:0] ax, ay, input logic an, input logic [1:0] fm);
        while ($urandom_range(99) < idle_pct) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid       <= 1'b1;
        req.vb_left     <= vbl;
        req.vb_top      <= vbt;
        req.vb_right    <= vbr;
        req.vb_bottom   <= vbb;
        req.elem_left   <= el;
        req.elem_top    <= et;
        req.elem_right  <= er;
        req.elem_bottom <= eb;
        req.align_x     <= ax;
        req.align_y     <= ay;
        req.align_none  <= an;
        req.fit_mode    <= fm;
        do @(posedge i_clk); while (!req.ready);
        sent++;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($urandom_range(2000)) * Q;
            2: return (int'($urandom_range(4000)) - 2000) <<< 12;
            3: case ($urandom_range(3))
                   0: return 32'h7fff_ffff;
                   1: return 32'h8000_0000;
                   2: return 32'h0;
                   default: return 32'hffff_ffff;
               endcase
            default: return 32'($urandom_range(1023)) << 10;
        endcase
    endfunction

    function automatic logic [31:0] rand_far(input logic [31:0] lo);
        case ($urandom_range(19))
            0: return lo;
            1: return $urandom;
            2: return lo - 32'($urandom_range(300 * Q));
            default: return lo + 32'($urandom_range(1, 500 * Q));
        endcase
    endfunction

    task automatic random_item();
        logic [31:0] vbl, vbt, el, et;
        vbl = rand_coord();
        vbt = rand_coord();
        el  = rand_coord();
        et  = rand_coord();
        issue(vbl, vbt, rand_far(vbl), rand_far(vbt), el, et, rand_far(el), rand_far(et),
              2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)),
              2'($urandom_range(3)));
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [DENS_W-1:0] dens, input int idle, input int stall,
                             input int n);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= dens;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n) random_item();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        req.valid       = 1'b0;
        req.vb_left     = '0;
        req.vb_top      = '0;
        req.vb_right    = '0;
        req.vb_bottom   = '0;
        req.elem_left   = '0;
        req.elem_top    = '0;
        req.elem_right  = '0;
        req.elem_bottom = '0;
        req.align_x     = ALIGN_MIN;
        req.align_y     = ALIGN_MIN;
        req.align_none  = 1'b0;
        req.fit_mode    = FIT_NONE;
        idle_pct        = 0;
        stall_pct       = 0;
        cycles          = 0;
        sent            = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cases at the reset density
        issue(0, 0, 100*Q, 50*Q, 0, 0, 200*Q, 200*Q, ALIGN_MID, ALIGN_MID, 1'b0, FIT_MEET);
        issue(0, 0, 100*Q, 50*Q, 0, 0, 200*Q, 200*Q, ALIGN_MAX, ALIGN_MAX, 1'b0, FIT_SLICE);
        issue(0, 0, 100*Q, 50*Q, 0, 0, 200*Q, 200*Q, ALIGN_MIN, ALIGN_MAX, 1'b0, FIT_SLICE);
        issue(10*Q, 5*Q, 90*Q, 70*Q, 3*Q, 4*Q, 60*Q, 40*Q, ALIGN_MAX, ALIGN_MIN, 1'b1,
              FIT_NONE);
        issue(10*Q, 5*Q, 90*Q, 70*Q, 3*Q, 4*Q, 60*Q, 40*Q, ALIGN_MID, ALIGN_MAX, 1'b0, 2'd3);
        issue(10*Q, 5*Q, 90*Q, 70*Q, 3*Q, 4*Q, 60*Q, 40*Q, ALIGN_MAX, ALIGN_MID, 1'b1,
              FIT_MEET);
        issue(10*Q, 5*Q, 90*Q, 70*Q, 3*Q, 4*Q, 60*Q, 40*Q, ALIGN_MAX, ALIGN_MID, 1'b1,
              FIT_SLICE);
        issue(10*Q, 5*Q, 90*Q, 70*Q, 3*Q, 4*Q, 60*Q, 40*Q, 2'd3, 2'd3, 1'b0, FIT_MEET);
        // zero width, zero height
        issue(7*Q, 0, 7*Q, 9*Q, 0, 0, Q, Q, ALIGN_MID, ALIGN_MID, 1'b0, FIT_MEET);
        issue(0, 7*Q, 9*Q, 7*Q, 0, 0, Q, Q, ALIGN_MID, ALIGN_MID, 1'b0, FIT_SLICE);
        // field extremes
        issue(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
              ALIGN_MAX, ALIGN_MAX, 1'b0, FIT_SLICE);
        issue(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
              ALIGN_MID, ALIGN_MIN, 1'b0, FIT_MEET);
        // reversed viewbox, reversed element
        issue(50*Q, 40*Q, 10*Q, 0, 0, 0, 30*Q, 30*Q, ALIGN_MAX, ALIGN_MID, 1'b0, FIT_MEET);
        issue(0, 0, 10*Q, 20*Q, 30*Q, 30*Q, -5*Q, 2*Q, ALIGN_MIN, ALIGN_MAX, 1'b0, FIT_SLICE);
        // one-lsb viewbox, scale saturates
        issue(0, 0, 1, 1, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, ALIGN_MID, ALIGN_MID, 1'b0,
              FIT_MEET);
        issue(0, 0, 1, 1, 32'h7fff_ffff, 0, 0, 32'h7fff_ffff, ALIGN_MAX, ALIGN_MAX, 1'b1,
              FIT_NONE);
        // far-off viewbox, product cap and shift saturation
        issue(32'h7fff_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_ffff,
              0, 0, 32'h7fff_ffff, 32'h7fff_ffff, ALIGN_MAX, ALIGN_MIN, 1'b0, FIT_SLICE);
        issue(32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 32'hffff_ffff, 2'd3, 2'd3, 1'b1, 2'd3);
        issue(1, 2, 3, 4, 5, 6, 7, 8, ALIGN_MID, ALIGN_MAX, 1'b1, 2'd3);

        // random phases across the density range and idling patterns
        run_phase(16'd0,     0,  0,  10);
        run_phase(16'd256,   0,  0, 130);
        run_phase(16'hffff, 88,  0, 130);
        run_phase(16'd1,     0, 88, 130);
        run_phase(16'($urandom_range(1, 65535)), 23, 23, 70);
        run_phase(16'd384,   0,  0,  60);

        drain();
        $display("%0d requests sent, %0d results checked (%0d with zero extent)",
                 sent, checked, zero_seen);
        $display("density settings 0, 1.0, max, 1 lsb, random, 1.5 with sender/receiver idling");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
